// File: sv/byte_ring_buffer_fifo_assert.svh
// Assertion macros used by the byte ring buffer FIFO top level.
`ifndef BYTE_RING_BUFFER_FIFO_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define BRB_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BRB_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BRB_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/brb_pkg.sv
// Shared types, opcodes and defaults for the byte ring buffer FIFO.
package brb_pkg;

  // Default sizing
  localparam int DEPTH_DEF    = 1024;
  localparam int MAX_XFER_DEF = 64;

  // Opcodes
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_DEQUEUE = 3'd1;
  localparam logic [2:0] OP_PEEK    = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_SKIP    = 3'd4;

  // Input word
  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] transfer_size;
    logic [7:0] data_byte;
  } item_t;

  // Output word
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_out;
    logic       last;
    logic       flag_full;
    logic       flag_empty;
    logic       flag_bad_size;
    logic [9:0] used_count;
  } result_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd;
    logic load_stat;
    logic load_byte;
  } brb_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic read_go;
    logic out_free;
    logic last_byte;
  } brb_stat_t;

endpackage

// File: sv/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/brb_ctrl.sv
// Controller state machine for the byte ring buffer FIFO.
module brb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  brb_pkg::brb_stat_t stat,
  output brb_pkg::brb_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_STAT = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = stat.read_go ? S_RD : S_STAT;
      end
      S_STAT: begin
        if (stat.out_free) begin
          ctl.load_stat = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        if (stat.out_free) begin
          ctl.load_byte = 1'b1;
          state_next    = stat.last_byte ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/brb_datapath.sv
// Datapath for the byte ring buffer FIFO: pointers, flags, store and result register.
module brb_datapath #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  brb_pkg::item_t     item,
  input  brb_pkg::brb_ctl_t  ctl,
  output brb_pkg::brb_stat_t stat,
  output logic               result_valid,
  input  logic               result_ready,
  output brb_pkg::result_t   result
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = PW + 1;
  localparam int LW = (PW > 7) ? PW : 7;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [6:0]    MAX_C    = 7'(MAX_XFER);

  logic [PW-1:0] front;
  logic [PW-1:0] rear;
  logic          fail_full;
  logic          fail_empty;
  logic          fail_size;
  logic [6:0]    run_offset;
  logic          run_accepted;
  brb_pkg::item_t cur;
  logic [PW-1:0] rd_ptr;
  logic [6:0]    rd_left;

  logic [CW-1:0] used_w;
  logic [PW-1:0] used;
  logic [PW-1:0] free;
  logic [LW-1:0] size_l;
  logic [CW-1:0] front_sum;
  logic [PW-1:0] front_adv;
  logic [PW-1:0] rear_inc;
  logic [PW-1:0] rd_inc;
  logic [6:0]    off_inc;
  logic [7:0]    rd_data;
  logic          any_fail;
  logic          size_zero;
  logic          size_big;
  logic          too_few;
  logic          no_room;
  logic          is_read;
  logic          read_ok;
  logic          wr_first;
  logic          wr_acc;
  logic          wr_do;
  logic          run_end;

  // Occupancy and free space, one slot kept empty
  always_comb begin
    if (rear >= front) begin
      used_w = CW'(rear) - CW'(front);
    end else begin
      used_w = DEPTH_C - CW'(front) + CW'(rear);
    end
    used = used_w[PW-1:0];
    free = LAST_PTR - used;
  end

  // Size checks
  assign size_l    = LW'(cur.transfer_size);
  assign any_fail  = fail_full | fail_empty | fail_size;
  assign size_zero = (cur.transfer_size == 7'd0);
  assign size_big  = (cur.transfer_size > MAX_C);
  assign too_few   = (LW'(used) < size_l);
  assign no_room   = (LW'(free) < size_l);

  // Pointer arithmetic with wrap at DEPTH
  assign front_sum = CW'(front) + CW'(size_l);
  assign front_adv = (front_sum >= DEPTH_C) ? PW'(front_sum - DEPTH_C) : front_sum[PW-1:0];
  assign rear_inc  = (rear == LAST_PTR) ? '0 : rear + PW'(1);
  assign rd_inc    = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);

  // Read decision
  assign is_read = (cur.opcode == brb_pkg::OP_DEQUEUE) || (cur.opcode == brb_pkg::OP_PEEK) ||
                   (cur.opcode == brb_pkg::OP_SKIP);
  assign read_ok = is_read && !any_fail && !size_big && !too_few;

  // Write run decision
  assign wr_first = (run_offset == 7'd0);
  assign wr_acc   = wr_first ? (!any_fail && !size_big && !no_room) : run_accepted;
  assign wr_do    = (cur.opcode == brb_pkg::OP_WRITE) && !size_zero && wr_acc;
  assign off_inc  = run_offset + 7'd1;
  assign run_end  = (off_inc >= cur.transfer_size);

  // Status to controller
  assign stat.read_go   = read_ok && !size_zero &&
                          ((cur.opcode == brb_pkg::OP_DEQUEUE) || (cur.opcode == brb_pkg::OP_PEEK));
  assign stat.out_free  = !result_valid || result_ready;
  assign stat.last_byte = (rd_left == 7'd1);

  // Byte store
  brb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.exec && wr_do),
    .waddr (rear),
    .wdata (cur.data_byte),
    .re    (ctl.rd),
    .raddr (rd_ptr),
    .rdata (rd_data)
  );

  // Capture the input word
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur <= item;
    end
  end

  // Execute the captured word against pointers, flags and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      front        <= '0;
      rear         <= '0;
      fail_full    <= 1'b0;
      fail_empty   <= 1'b0;
      fail_size    <= 1'b0;
      run_offset   <= '0;
      run_accepted <= 1'b0;
    end else if (ctl.exec) begin
      case (cur.opcode)
        brb_pkg::OP_WRITE: begin
          if (!size_zero) begin
            if (wr_first && !any_fail) begin
              if (size_big) begin
                fail_size <= 1'b1;
              end else if (no_room) begin
                fail_full <= 1'b1;
              end
            end
            if (wr_do) begin
              rear <= rear_inc;
            end
            if (run_end) begin
              run_offset   <= '0;
              run_accepted <= 1'b0;
            end else begin
              run_offset   <= off_inc;
              run_accepted <= wr_acc;
            end
          end
        end
        brb_pkg::OP_DEQUEUE, brb_pkg::OP_PEEK, brb_pkg::OP_SKIP: begin
          run_offset   <= '0;
          run_accepted <= 1'b0;
          if (!any_fail) begin
            if (size_big) begin
              fail_size <= 1'b1;
            end else if (too_few) begin
              fail_empty <= 1'b1;
            end else if (cur.opcode != brb_pkg::OP_PEEK) begin
              front <= front_adv;
            end
          end
        end
        brb_pkg::OP_CLEAR: begin
          run_offset   <= '0;
          run_accepted <= 1'b0;
          front        <= '0;
          rear         <= '0;
          fail_full    <= 1'b0;
          fail_empty   <= 1'b0;
          fail_size    <= 1'b0;
        end
        default: begin
          run_offset   <= '0;
          run_accepted <= 1'b0;
        end
      endcase
    end
  end

  // Read walker: start at the old front, step once per emitted byte
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rd_ptr  <= front;
      rd_left <= cur.transfer_size;
    end else if (ctl.load_byte) begin
      rd_ptr  <= rd_inc;
      rd_left <= rd_left - 7'd1;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.load_stat || ctl.load_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ctl.load_stat || ctl.load_byte) begin
      result.byte_valid    <= ctl.load_byte;
      result.data_out      <= ctl.load_byte ? rd_data : 8'd0;
      result.last          <= ctl.load_stat || (rd_left == 7'd1);
      result.flag_full     <= fail_full;
      result.flag_empty    <= fail_empty;
      result.flag_bad_size <= fail_size;
      result.used_count    <= 10'(used);
    end
  end

endmodule

// File: sv/byte_ring_buffer_fifo.sv
// Byte ring buffer FIFO top level: controller, datapath and checks.
//
// Byte FIFO over DEPTH slots holding at most DEPTH-1 bytes. Every input word
// returns one status word (last set, flags, used count) unless it is a dequeue
// or peek that emits bytes, in which case one word per byte comes back and the
// final one carries last. Sticky full, empty and bad-size flags block all
// operations but clear. A write, clear, skip or refused read goes through
// accept, execute and status load; a dequeue or peek of N bytes goes
// through accept and execute, then for each byte a read of the store's
// registered read port and a load of the result register. A stalled result
// side delays these loads. The store needs no clearing pass after reset.
module byte_ring_buffer_fifo #(
  parameter int DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int MAX_XFER = brb_pkg::MAX_XFER_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  brb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output brb_pkg::result_t result
);

  brb_pkg::brb_ctl_t  ctl;
  brb_pkg::brb_stat_t stat;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .ctl        (ctl)
  );

  brb_datapath #(
    .DEPTH    (DEPTH),
    .MAX_XFER (MAX_XFER)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `include "byte_ring_buffer_fifo_assert.svh"

  // Never load the result register over a word that is not taken
  `BRB_IMPLIES(a_load_free, ctl.load_stat || ctl.load_byte, stat.out_free, "result overwritten")
  // Status and byte loads are exclusive
  `BRB_CHECK(a_one_load, !(ctl.load_stat && ctl.load_byte), "two result loads at once")
  // Emitted bytes only come while no flag is set
  `BRB_IMPLIES(a_byte_no_flag, result_valid && result.byte_valid,
    !(result.flag_full || result.flag_empty || result.flag_bad_size), "byte with flag set")
  // Busy after accepting a word
  `BRB_NEXT(a_busy, item_valid && item_ready, !item_ready, "ready right after accept")

endmodule
